// ===== design/hrt_pkg.sv =====
// shared types, codes and constants of the hessian reply tokenizer
// no dependencies
package hrt_pkg;

  localparam int unsigned MaxDepth = 16;
  localparam int unsigned DepthW   = $clog2(MaxDepth + 1);
  localparam int unsigned IdxW     = $clog2(MaxDepth);

  typedef enum logic [16:0] {
    PH_START      = 17'h00001,
    PH_VER1       = 17'h00002,
    PH_VER2       = 17'h00004,
    PH_TOP        = 17'h00008,
    PH_VALUE      = 17'h00010,
    PH_LIST_T     = 17'h00020,
    PH_LIST_L     = 17'h00040,
    PH_MAP_T      = 17'h00080,
    PH_REMOTE_T   = 17'h00100,
    PH_REMOTE_S   = 17'h00200,
    PH_NUM        = 17'h00400,
    PH_SKIP       = 17'h00800,
    PH_LEN_HI     = 17'h01000,
    PH_LEN_LO     = 17'h02000,
    PH_PAYLOAD    = 17'h04000,
    PH_CHUNK_CONT = 17'h08000,
    PH_END        = 17'h10000
  } phase_e;

  localparam logic [4:0] TkNull     = 5'd0;
  localparam logic [4:0] TkTrue     = 5'd1;
  localparam logic [4:0] TkFalse    = 5'd2;
  localparam logic [4:0] TkInt      = 5'd3;
  localparam logic [4:0] TkLong     = 5'd4;
  localparam logic [4:0] TkDate     = 5'd5;
  localparam logic [4:0] TkDouble   = 5'd6;
  localparam logic [4:0] TkStr      = 5'd7;
  localparam logic [4:0] TkXml      = 5'd8;
  localparam logic [4:0] TkBin      = 5'd9;
  localparam logic [4:0] TkList     = 5'd10;
  localparam logic [4:0] TkMap      = 5'd11;
  localparam logic [4:0] TkEnd      = 5'd12;
  localparam logic [4:0] TkType     = 5'd13;
  localparam logic [4:0] TkHdr      = 5'd14;
  localparam logic [4:0] TkRemote   = 5'd15;
  localparam logic [4:0] TkFault    = 5'd16;
  localparam logic [4:0] TkChunkEnd = 5'd17;
  localparam logic [4:0] TkDone     = 5'd18;
  localparam logic [4:0] TkError    = 5'd19;

  localparam logic [2:0] ErrNone    = 3'd0;
  localparam logic [2:0] ErrUnknown = 3'd1;
  localparam logic [2:0] ErrUnexp   = 3'd2;
  localparam logic [2:0] ErrBadLen  = 3'd3;
  localparam logic [2:0] ErrTrunc   = 3'd4;
  localparam logic [2:0] ErrTrail   = 3'd5;
  localparam logic [2:0] ErrDepth   = 3'd6;

  localparam logic [1:0] StkList  = 2'd0;
  localparam logic [1:0] StkKey   = 2'd1;
  localparam logic [1:0] StkValue = 2'd2;

  localparam logic [1:0] ChunkStr = 2'd0;
  localparam logic [1:0] ChunkXml = 2'd1;
  localparam logic [1:0] ChunkBin = 2'd2;

  localparam logic [7:0] ChRLo = 8'h72;
  localparam logic [7:0] ChHUp = 8'h48;
  localparam logic [7:0] ChZLo = 8'h7a;
  localparam logic [7:0] ChNUp = 8'h4e;
  localparam logic [7:0] ChTUp = 8'h54;
  localparam logic [7:0] ChFUp = 8'h46;
  localparam logic [7:0] ChIUp = 8'h49;
  localparam logic [7:0] ChLUp = 8'h4c;
  localparam logic [7:0] ChDLo = 8'h64;
  localparam logic [7:0] ChDUp = 8'h44;
  localparam logic [7:0] ChSLo = 8'h73;
  localparam logic [7:0] ChSUp = 8'h53;
  localparam logic [7:0] ChXLo = 8'h78;
  localparam logic [7:0] ChXUp = 8'h58;
  localparam logic [7:0] ChBLo = 8'h62;
  localparam logic [7:0] ChBUp = 8'h42;
  localparam logic [7:0] ChVUp = 8'h56;
  localparam logic [7:0] ChMUp = 8'h4d;
  localparam logic [7:0] ChFLo = 8'h66;
  localparam logic [7:0] ChTLo = 8'h74;
  localparam logic [7:0] ChLLo = 8'h6c;

  typedef struct packed {
    logic [4:0]        kind;
    logic [63:0]       value;
    logic [2:0]        err;
    logic [DepthW-1:0] depth;
    logic              last;
  } token_t;

  typedef struct packed {
    logic [1:0] cnt;
    token_t     tok0;
    token_t     tok1;
  } step_t;

  function automatic logic [8:0] chunk_lower(input logic [1:0] ct);
    case (ct)
      ChunkStr: chunk_lower = {1'b0, ChSLo};
      ChunkXml: chunk_lower = {1'b0, ChXLo};
      ChunkBin: chunk_lower = {1'b0, ChBLo};
      default:  chunk_lower = 9'h100;
    endcase
  endfunction

  function automatic logic [8:0] chunk_upper(input logic [1:0] ct);
    case (ct)
      ChunkStr: chunk_upper = {1'b0, ChSUp};
      ChunkXml: chunk_upper = {1'b0, ChXUp};
      ChunkBin: chunk_upper = {1'b0, ChBUp};
      default:  chunk_upper = 9'h100;
    endcase
  endfunction

  function automatic logic [1:0] stk_toggle(input logic [1:0] code);
    case (code)
      StkKey:   stk_toggle = StkValue;
      StkValue: stk_toggle = StkKey;
      default:  stk_toggle = code;
    endcase
  endfunction

endpackage

// ===== design/hessian_reply_tokenizer.sv =====
// top level: input word register, parser and output token queue
// depends on hrt_pkg, hrt_parser, hrt_token_fifo
//
// channel   dir  tdata                         tuser       tlast
// s_axis    in   [7:0] data byte               -           end of message
// m_axis    out  [63:0] value [66:64] error    token kind  last token of byte
//                [71:67] depth
//
// one input word per cycle enters the parse stage while the queue has room; each
// word yields zero to two tokens
// the parse step is combinational from the input register into the queue
// input stalls only when fewer than two queue slots are free
// reset is asynchronous and returns the parser to expecting a reply start
module hessian_reply_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] data_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,  // [63:0] token_value, [66:64] error_code,
                                       // [71:67] nesting_depth
  output logic [4:0]  m_axis_tuser_o,  // [4:0] token_kind
  output logic        m_axis_tlast_o
);
  import hrt_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_eom_q;
  logic       room, step;
  step_t      res;
  token_t     tok;

  assign step            = in_valid_q && room;
  assign s_axis_tready_o = !in_valid_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_eom_q  <= s_axis_tlast_i;
    end
  end

  hrt_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .eom_i  (in_eom_q),
    .res_o  (res)
  );

  hrt_token_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (step),
    .res_i   (res),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .tok_o   (tok)
  );

  assign m_axis_tdata_o = {tok.depth, tok.err, tok.value};
  assign m_axis_tuser_o = tok.kind;
  assign m_axis_tlast_o = tok.last;

endmodule

// ===== design/hrt_parser.sv =====
// parse state, container stack and per-byte token generation
// depends on hrt_pkg
module hrt_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic [7:0]     byte_i,
  input  logic           eom_i,
  output hrt_pkg::step_t res_o
);
  import hrt_pkg::*;

  phase_e            phase_q, phase_d, pay_next_q, pay_next_d;
  logic [2:0]        fbc_q, fbc_d;
  logic [63:0]       vs_q, vs_d;
  logic [14:0]       br_q, br_d;
  logic [1:0]        ct_q, ct_d;
  logic [DepthW-1:0] depth_q, depth_d;
  logic              errl_q;
  logic              hdr_q, hdr_d;
  logic [4:0]        ptok_q, ptok_d;
  logic              cfin_q, cfin_d;
  logic [1:0]        top_q, top_d;
  logic [1:0]        stack_q [MaxDepth];

  logic [1:0]  n;
  logic [4:0]  k0, k1;
  logic [63:0] v0, v1;
  logic [2:0]  err;
  logic        done, vd, pop, push, disp, sc, sc_fin, pdone;
  logic [1:0]  sc_ct, push_code, top_src;
  logic [4:0]  push_kind;
  phase_e      push_next;
  logic [14:0] len;
  logic [IdxW-1:0] wr_idx, rd_idx;
  logic [DepthW-1:0] dm1, dm2;

  assign dm1    = depth_q - DepthW'(1);
  assign dm2    = depth_q - DepthW'(2);
  assign wr_idx = dm1[IdxW-1:0];
  assign rd_idx = dm2[IdxW-1:0];

  always_comb begin
    phase_d = phase_q; pay_next_d = pay_next_q; fbc_d = fbc_q; vs_d = vs_q;
    br_d = br_q; ct_d = ct_q; depth_d = depth_q; hdr_d = hdr_q;
    ptok_d = ptok_q; cfin_d = cfin_q; top_d = top_q;
    n = 2'd0; k0 = TkNull; k1 = TkNull; v0 = '0; v1 = '0;
    err = ErrNone; done = 1'b0; vd = 1'b0; pop = 1'b0; push = 1'b0;
    disp = 1'b0; sc = 1'b0; sc_fin = 1'b0; sc_ct = ChunkStr; pdone = 1'b0;
    push_code = StkList; push_kind = TkList; push_next = PH_VALUE;
    top_src = top_q; len = '0;

    unique case (phase_q)
      PH_START: begin
        if (byte_i == ChRLo) phase_d = PH_VER1;
        else err = ErrUnexp;
      end
      PH_VER1: phase_d = PH_VER2;
      PH_VER2: phase_d = PH_TOP;
      PH_TOP: begin
        if (byte_i == ChHUp) begin
          hdr_d = 1'b1; ptok_d = TkHdr; pay_next_d = PH_VALUE; phase_d = PH_LEN_HI;
        end else disp = 1'b1;
      end
      PH_VALUE: disp = 1'b1;
      PH_LIST_T: begin
        if (byte_i == ChTLo) begin
          ptok_d = TkType; pay_next_d = PH_LIST_L; phase_d = PH_LEN_HI;
        end else if (byte_i == ChLLo) begin
          fbc_d = 3'd3; phase_d = PH_SKIP;
        end else disp = 1'b1;
      end
      PH_LIST_L: begin
        if (byte_i == ChLLo) begin
          fbc_d = 3'd3; phase_d = PH_SKIP;
        end else disp = 1'b1;
      end
      PH_MAP_T: begin
        if (byte_i == ChTLo) begin
          ptok_d = TkType; pay_next_d = PH_VALUE; phase_d = PH_LEN_HI;
        end else disp = 1'b1;
      end
      PH_REMOTE_T: begin
        if (byte_i == ChTLo) begin
          ptok_d = TkType; pay_next_d = PH_REMOTE_S; phase_d = PH_LEN_HI;
        end else err = ErrUnexp;
      end
      PH_REMOTE_S: begin
        if (byte_i == ChSUp) begin
          sc = 1'b1; sc_ct = ChunkStr; sc_fin = 1'b1;
        end else err = ErrUnexp;
      end
      PH_NUM: begin
        vs_d = {vs_q[55:0], byte_i};
        if (fbc_q == 3'd0) begin
          k0 = ptok_q; v0 = vs_d; n = 2'd1; vd = 1'b1;
        end else fbc_d = fbc_q - 3'd1;
      end
      PH_SKIP: begin
        if (fbc_q == 3'd0) phase_d = PH_VALUE;
        else fbc_d = fbc_q - 3'd1;
      end
      PH_LEN_HI: begin
        if (byte_i[7]) err = ErrBadLen;
        else begin
          vs_d = {56'd0, byte_i}; phase_d = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        len  = {vs_q[6:0], byte_i};
        br_d = len;
        if (len == 15'd0) pdone = 1'b1;
        else phase_d = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        k0 = ptok_q; v0 = {56'd0, byte_i}; n = 2'd1;
        if (br_q != 15'd0) br_d = br_q - 15'd1;
        if (br_q <= 15'd1) pdone = 1'b1;
      end
      PH_CHUNK_CONT: begin
        if ({1'b0, byte_i} == chunk_lower(ct_q)) begin
          sc = 1'b1; sc_ct = ct_q; sc_fin = 1'b0;
        end else if ({1'b0, byte_i} == chunk_upper(ct_q)) begin
          sc = 1'b1; sc_ct = ct_q; sc_fin = 1'b1;
        end else err = ErrUnexp;
      end
      PH_END: begin
        if (byte_i == ChZLo) begin
          if (eom_i) begin
            k0 = TkDone; n = 2'd1; done = 1'b1;
          end else err = ErrTrail;
        end else err = ErrUnexp;
      end
      default: err = ErrUnexp;
    endcase

    if (disp) begin
      unique case (byte_i)
        ChNUp: begin k0 = TkNull;  n = 2'd1; vd = 1'b1; end
        ChTUp: begin k0 = TkTrue;  n = 2'd1; vd = 1'b1; end
        ChFUp: begin k0 = TkFalse; n = 2'd1; vd = 1'b1; end
        ChIUp: begin ptok_d = TkInt;    fbc_d = 3'd3; vs_d = '0; phase_d = PH_NUM; end
        ChLUp: begin ptok_d = TkLong;   fbc_d = 3'd7; vs_d = '0; phase_d = PH_NUM; end
        ChDLo: begin ptok_d = TkDate;   fbc_d = 3'd7; vs_d = '0; phase_d = PH_NUM; end
        ChDUp: begin ptok_d = TkDouble; fbc_d = 3'd7; vs_d = '0; phase_d = PH_NUM; end
        ChSLo: begin sc = 1'b1; sc_ct = ChunkStr; end
        ChSUp: begin sc = 1'b1; sc_ct = ChunkStr; sc_fin = 1'b1; end
        ChXLo: begin sc = 1'b1; sc_ct = ChunkXml; end
        ChXUp: begin sc = 1'b1; sc_ct = ChunkXml; sc_fin = 1'b1; end
        ChBLo: begin sc = 1'b1; sc_ct = ChunkBin; end
        ChBUp: begin sc = 1'b1; sc_ct = ChunkBin; sc_fin = 1'b1; end
        ChVUp: begin
          push = 1'b1; push_code = StkList; push_kind = TkList; push_next = PH_LIST_T;
        end
        ChMUp: begin
          push = 1'b1; push_code = StkKey; push_kind = TkMap; push_next = PH_MAP_T;
        end
        ChFLo: begin
          push = 1'b1; push_code = StkKey; push_kind = TkFault; push_next = PH_VALUE;
        end
        ChRLo: begin k0 = TkRemote; n = 2'd1; phase_d = PH_REMOTE_T; end
        ChZLo: begin
          if (depth_q != '0 && top_q != StkValue) begin
            pop = 1'b1; k0 = TkEnd; n = 2'd1; vd = 1'b1;
          end else err = ErrUnknown;
        end
        default: err = ErrUnknown;
      endcase
    end

    // container push
    if (push) begin
      if (depth_q >= DepthW'(MaxDepth)) begin
        err  = ErrDepth;
        push = 1'b0;
      end else begin
        depth_d = depth_q + DepthW'(1);
        top_d   = push_code;
        k0 = push_kind; n = 2'd1;
        phase_d = push_next;
      end
    end

    if (sc) begin
      ct_d = sc_ct; cfin_d = sc_fin;
      ptok_d = TkStr + {3'd0, sc_ct}; pay_next_d = PH_VALUE; phase_d = PH_LEN_HI;
    end

    // end of a length-prefixed run
    if (pdone) begin
      if (ptok_q == TkStr || ptok_q == TkXml || ptok_q == TkBin) begin
        if (n == 2'd0) begin
          k0 = TkChunkEnd; v0 = {63'd0, cfin_q};
        end else begin
          k1 = TkChunkEnd; v1 = {63'd0, cfin_q};
        end
        n = n + 2'd1;
        if (cfin_q) vd = 1'b1;
        else phase_d = PH_CHUNK_CONT;
      end else phase_d = pay_next_q;
    end

    if (pop) begin
      depth_d = dm1;
      top_src = stack_q[rd_idx];
    end

    // a value completed
    if (vd) begin
      if (depth_d == '0) begin
        phase_d = hdr_q ? PH_TOP : PH_END;
        hdr_d   = 1'b0;
      end else begin
        top_d   = stk_toggle(top_src);
        phase_d = PH_VALUE;
      end
    end

    if (err == ErrNone && eom_i && !done) err = ErrTrunc;
  end

  always_comb begin
    res_o = '0;
    if (!errl_q) begin
      if (err != ErrNone) begin
        res_o.cnt        = 2'd1;
        res_o.tok0.kind  = TkError;
        res_o.tok0.err   = err;
        res_o.tok0.depth = depth_d;
        res_o.tok0.last  = 1'b1;
      end else begin
        res_o.cnt        = n;
        res_o.tok0.kind  = k0;
        res_o.tok0.value = v0;
        res_o.tok0.depth = depth_d;
        res_o.tok0.last  = (n == 2'd1);
        res_o.tok1.kind  = k1;
        res_o.tok1.value = v1;
        res_o.tok1.depth = depth_d;
        res_o.tok1.last  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_START;
      pay_next_q <= PH_START;
      fbc_q      <= '0;
      vs_q       <= '0;
      br_q       <= '0;
      ct_q       <= '0;
      depth_q    <= '0;
      errl_q     <= 1'b0;
      hdr_q      <= 1'b0;
      ptok_q     <= '0;
      cfin_q     <= 1'b0;
    end else if (step_i) begin
      if (errl_q || (err != ErrNone && eom_i) || done) begin
        if (eom_i) begin
          phase_q    <= PH_START;
          pay_next_q <= PH_START;
          fbc_q      <= '0;
          vs_q       <= '0;
          br_q       <= '0;
          ct_q       <= '0;
          depth_q    <= '0;
          errl_q     <= 1'b0;
          hdr_q      <= 1'b0;
          ptok_q     <= '0;
          cfin_q     <= 1'b0;
        end
      end else begin
        phase_q    <= phase_d;
        pay_next_q <= pay_next_d;
        fbc_q      <= fbc_d;
        vs_q       <= vs_d;
        br_q       <= br_d;
        ct_q       <= ct_d;
        depth_q    <= depth_d;
        hdr_q      <= hdr_d;
        ptok_q     <= ptok_d;
        cfin_q     <= cfin_d;
        errl_q     <= (err != ErrNone);
      end
    end
  end

  // stack holds the entries below the top, the top lives in top_q
  always_ff @(posedge clk_i) begin
    if (step_i && !errl_q) begin
      top_q <= top_d;
      if (push && depth_q != '0) stack_q[wr_idx] <= top_q;
    end
  end

endmodule

// ===== design/hrt_token_fifo.sv =====
// four-entry token queue between the parser and the output port
// depends on hrt_pkg
module hrt_token_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  hrt_pkg::step_t  res_i,
  output logic            room_o,
  output logic            valid_o,
  input  logic            ready_i,
  output hrt_pkg::token_t tok_o
);
  import hrt_pkg::*;

  token_t     mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic [1:0] nwr;
  logic       rd;

  assign room_o  = (cnt_q <= 3'd2);
  assign valid_o = (cnt_q != 3'd0);
  assign tok_o   = mem_q[rp_q];
  assign rd      = valid_o && ready_i;
  assign nwr     = wr_i ? res_i.cnt : 2'd0;

  always_ff @(posedge clk_i) begin
    if (nwr != 2'd0) mem_q[wp_q] <= res_i.tok0;
    if (nwr == 2'd2) mem_q[wp_q + 2'd1] <= res_i.tok1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + nwr;
      rp_q  <= rp_q + {1'b0, rd};
      cnt_q <= cnt_q + {1'b0, nwr} - {2'b0, rd};
    end
  end

endmodule
